// ===== rtl/bwt_pkg.sv =====
// Shared constants and command codes of the byte wavelet tree block.
`timescale 1ns / 1ps

package bwt_pkg;

  // Default text capacity in symbols.
  localparam int unsigned MAX_LEN_DEF = 4096;

  // One tree level for each bit of a byte symbol.
  localparam int unsigned LEVELS = 8;
  localparam int unsigned LVL_W  = 3;
  localparam int unsigned SYM_W  = 8;

  // Port widths of the query position and of the answer.
  localparam int unsigned POS_W  = 13;
  localparam int unsigned ANS_W  = 13;

  // Number of counting-sort buckets; one for each byte key.
  localparam int unsigned BKT_N  = 256;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ACCESS = 2'd1,
    CMD_RANK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

endpackage

// ===== rtl/bwt_walk_step.sv =====
// One level of the tree walk: narrows the node interval and the query index.
`timescale 1ns / 1ps

module bwt_walk_step #(
  parameter int unsigned LEN_W = $clog2(bwt_pkg::MAX_LEN_DEF + 1)
) (
  input  logic [LEN_W-1:0] pos_i,
  input  logic [LEN_W-1:0] idx_i,
  input  logic [LEN_W-1:0] len_i,
  input  logic [LEN_W-1:0] zp_i,
  input  logic [LEN_W-1:0] dz_i,
  input  logic [LEN_W-1:0] zend_i,
  input  logic             bit_i,
  output logic [LEN_W-1:0] pos_o,
  output logic [LEN_W-1:0] idx_o,
  output logic [LEN_W-1:0] len_o
);

  logic [LEN_W-1:0] zn;

  // Zeros inside the current node.
  assign zn = zend_i - zp_i;

  always_comb begin
    if (bit_i) begin
      // The ones child follows all zeros of the node.
      pos_o = pos_i + zn;
      idx_o = idx_i - dz_i;
      len_o = len_i - zn;
    end else begin
      pos_o = pos_i;
      idx_o = dz_i;
      len_o = zn;
    end
  end

endmodule

// ===== rtl/byte_wavelet_tree_access_rank.sv =====
// Top level of the byte wavelet tree with load, access and rank commands.
// An overflowing load, an out-of-range query or a rank at position zero answers in the next cycle.
// A load marked last starts the build of all levels.
// A query holds busy while it walks the levels through S_Q0 to S_Q3, then registers its answer.
// The receiver cannot stall; each result shows for one cycle under valid_o.
// Reset clears length and built flag; the text and tree memories are not cleared.
`timescale 1ns / 1ps

module byte_wavelet_tree_access_rank #(
  parameter int unsigned MAX_LEN = bwt_pkg::MAX_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd_i,
  input  logic [bwt_pkg::SYM_W-1:0]  text_byte_i,
  input  logic                       load_last_i,
  input  logic [bwt_pkg::POS_W-1:0]  position_i,
  input  logic [bwt_pkg::SYM_W-1:0]  symbol_i,
  output logic                       valid_o,
  output logic [bwt_pkg::ANS_W-1:0]  answer_o,
  output logic                       error_o
);

  // Index width of a text position, and width of a length that may reach MAX_LEN.
  localparam int unsigned KW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  // Common width for comparing the query position against the length.
  localparam int unsigned CW = (LW > bwt_pkg::POS_W) ? LW : bwt_pkg::POS_W;
  localparam int unsigned DW = bwt_pkg::LVL_W;
  localparam int unsigned SW = bwt_pkg::SYM_W;
  localparam int unsigned BW = $clog2(bwt_pkg::BKT_N);

  // The sequencer. The build runs five sweeps for each level: clear the buckets,
  // count keys while writing the level bits and zero prefix counts, turn the counts
  // into start offsets, place the symbols stably, and copy them back for the next level.
  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_CLR  = 16'h0002,
    S_CNT0 = 16'h0004,
    S_CNT1 = 16'h0008,
    S_CNT2 = 16'h0010,
    S_PFX0 = 16'h0020,
    S_PFX1 = 16'h0040,
    S_PLC0 = 16'h0080,
    S_PLC1 = 16'h0100,
    S_PLC2 = 16'h0200,
    S_CPY0 = 16'h0400,
    S_CPY1 = 16'h0800,
    S_Q0   = 16'h1000,
    S_Q1   = 16'h2000,
    S_Q2   = 16'h4000,
    S_Q3   = 16'h8000
  } state_e;

  state_e state_q, state_d;

  logic [LW-1:0] len_q, len_d;
  logic          built_q, built_d;
  logic [LW-1:0] k_q, k_d;
  logic [BW-1:0] j_q, j_d;
  logic [DW-1:0] lvl_q, lvl_d;
  logic [LW-1:0] zc_q, zc_d;
  logic [LW-1:0] sum_q, sum_d;
  logic [SW-1:0] key_q, key_d;
  logic [SW-1:0] sym_q, sym_d;

  logic          acc_q, acc_d;
  logic [SW-1:0] qsym_q, qsym_d;
  logic [LW-1:0] pos_q, pos_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [LW-1:0] wlen_q, wlen_d;
  logic [LW-1:0] zp_q, zp_d;
  logic [LW-1:0] dz_q, dz_d;
  logic          bit_q, bit_d;
  logic [SW-1:0] value_q, value_d;

  logic                       valid_q, valid_d;
  logic [bwt_pkg::ANS_W-1:0]  answer_q, answer_d;
  logic                       error_q, error_d;

  // Memories. The text buffer doubles as the symbol order of the current level.
  logic [SW-1:0] tbuf_mem  [MAX_LEN];
  logic [SW-1:0] ordb_mem  [MAX_LEN];
  logic          lbit_mem  [bwt_pkg::LEVELS << KW];
  logic [LW-1:0] zpc_mem   [bwt_pkg::LEVELS << LW];
  logic [LW-1:0] bkt_mem   [bwt_pkg::BKT_N];

  logic          tbuf_we;
  logic [KW-1:0] tbuf_waddr, tbuf_raddr;
  logic [SW-1:0] tbuf_wdata, tbuf_rd_q;

  logic          ordb_we;
  logic [KW-1:0] ordb_waddr;
  logic [SW-1:0] ordb_rd_q;

  logic             lbit_we;
  logic [DW+KW-1:0] lbit_waddr, lbit_raddr;
  logic             lbit_wdata, lbit_rd_q;

  logic             zpc_we;
  logic [DW+LW-1:0] zpc_waddr, zpc_raddr;
  logic [LW-1:0]    zpc_wdata, zpc_rd_q;

  logic          bkt_we;
  logic [BW-1:0] bkt_waddr, bkt_raddr;
  logic [LW-1:0] bkt_wdata, bkt_rd_q;

  // Shared shift unit: the sort key of a symbol at the current level is its top lvl+1 bits.
  logic [DW-1:0] key_sh;
  logic [SW-1:0] cur_key;
  logic          cur_bit;

  logic [LW-1:0] base_len;
  logic [CW-1:0] pos_ext, n_ext;
  logic [LW-1:0] pos_idx, pos_len;
  logic [LW-1:0] step_pos, step_idx, step_len;
  logic [SW-1:0] value_nx;
  logic [CW-1:0] idx_ext;
  logic          q_bit;

  assign key_sh  = DW'(bwt_pkg::LEVELS - 1) - lvl_q;
  assign cur_key = tbuf_rd_q >> key_sh;
  assign cur_bit = cur_key[0];

  // A load after a finished build starts a fresh text.
  assign base_len = built_q ? '0 : len_q;
  // Until a build finishes, the text counts as empty for queries.
  assign pos_ext  = CW'(position_i);
  assign n_ext    = built_q ? CW'(len_q) : '0;

  assign pos_idx  = pos_q + idx_q;
  assign pos_len  = pos_q + wlen_q;
  assign q_bit    = acc_q ? lbit_rd_q : qsym_q[key_sh];
  assign value_nx = {value_q[SW-2:0], bit_q};
  assign idx_ext  = CW'(step_idx);

  bwt_walk_step #(
    .LEN_W (LW)
  ) u_step (
    .pos_i  (pos_q),
    .idx_i  (idx_q),
    .len_i  (wlen_q),
    .zp_i   (zp_q),
    .dz_i   (dz_q),
    .zend_i (zpc_rd_q),
    .bit_i  (bit_q),
    .pos_o  (step_pos),
    .idx_o  (step_idx),
    .len_o  (step_len)
  );

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    built_d  = built_q;
    k_d      = k_q;
    j_d      = j_q;
    lvl_d    = lvl_q;
    zc_d     = zc_q;
    sum_d    = sum_q;
    key_d    = key_q;
    sym_d    = sym_q;
    acc_d    = acc_q;
    qsym_d   = qsym_q;
    pos_d    = pos_q;
    idx_d    = idx_q;
    wlen_d   = wlen_q;
    zp_d     = zp_q;
    dz_d     = dz_q;
    bit_d    = bit_q;
    value_d  = value_q;
    valid_d  = 1'b0;
    answer_d = answer_q;
    error_d  = error_q;

    tbuf_we    = 1'b0;
    tbuf_waddr = k_q[KW-1:0];
    tbuf_wdata = ordb_rd_q;
    tbuf_raddr = k_q[KW-1:0];
    ordb_we    = 1'b0;
    ordb_waddr = bkt_rd_q[KW-1:0];
    lbit_we    = 1'b0;
    lbit_waddr = {lvl_q, k_q[KW-1:0]};
    lbit_wdata = cur_bit;
    lbit_raddr = {lvl_q, pos_idx[KW-1:0]};
    zpc_we     = 1'b0;
    zpc_waddr  = {lvl_q, k_q + LW'(1)};
    zpc_wdata  = zc_q;
    zpc_raddr  = {lvl_q, pos_q};
    bkt_we     = 1'b0;
    bkt_waddr  = key_q;
    bkt_wdata  = bkt_rd_q + LW'(1);
    bkt_raddr  = cur_key;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (bwt_pkg::cmd_e'(cmd_i))
            bwt_pkg::CMD_LOAD: begin
              built_d = 1'b0;
              if (base_len < LW'(MAX_LEN)) begin
                tbuf_we    = 1'b1;
                tbuf_waddr = base_len[KW-1:0];
                tbuf_wdata = text_byte_i;
                len_d      = base_len + LW'(1);
              end else begin
                len_d    = base_len;
                valid_d  = 1'b1;
                answer_d = '0;
                error_d  = 1'b1;
              end
              if (load_last_i) begin
                lvl_d   = '0;
                j_d     = '0;
                state_d = S_CLR;
              end
            end
            bwt_pkg::CMD_ACCESS: begin
              if (pos_ext >= n_ext) begin
                valid_d  = 1'b1;
                answer_d = '0;
                error_d  = 1'b1;
              end else begin
                acc_d   = 1'b1;
                pos_d   = '0;
                idx_d   = LW'(position_i);
                wlen_d  = len_q;
                lvl_d   = '0;
                value_d = '0;
                state_d = S_Q0;
              end
            end
            bwt_pkg::CMD_RANK: begin
              if (pos_ext > n_ext) begin
                valid_d  = 1'b1;
                answer_d = '0;
                error_d  = 1'b1;
              end else if (pos_ext == '0) begin
                valid_d  = 1'b1;
                answer_d = '0;
                error_d  = 1'b0;
              end else begin
                acc_d   = 1'b0;
                qsym_d  = symbol_i;
                pos_d   = '0;
                idx_d   = LW'(position_i);
                wlen_d  = len_q;
                lvl_d   = '0;
                value_d = '0;
                state_d = S_Q0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_CLR: begin
        bkt_we    = 1'b1;
        bkt_waddr = j_q;
        bkt_wdata = '0;
        if (j_q == '0) begin
          zpc_we    = 1'b1;
          zpc_waddr = {lvl_q, LW'(0)};
          zpc_wdata = '0;
          zc_d      = '0;
        end
        j_d = j_q + BW'(1);
        if (j_q == '1) begin
          k_d     = '0;
          state_d = S_CNT0;
        end
      end

      S_CNT0: begin
        if (k_q == len_q) begin
          j_d     = '0;
          sum_d   = '0;
          state_d = S_PFX0;
        end else begin
          state_d = S_CNT1;
        end
      end

      S_CNT1: begin
        lbit_we   = 1'b1;
        zc_d      = zc_q + LW'(!cur_bit);
        zpc_we    = 1'b1;
        zpc_wdata = zc_d;
        key_d     = cur_key;
        state_d   = S_CNT2;
      end

      S_CNT2: begin
        bkt_we  = 1'b1;
        k_d     = k_q + LW'(1);
        state_d = S_CNT0;
      end

      S_PFX0: begin
        bkt_raddr = j_q;
        state_d   = S_PFX1;
      end

      S_PFX1: begin
        bkt_we    = 1'b1;
        bkt_waddr = j_q;
        bkt_wdata = sum_q;
        sum_d     = sum_q + bkt_rd_q;
        j_d       = j_q + BW'(1);
        if (j_q == '1) begin
          k_d     = '0;
          state_d = S_PLC0;
        end else begin
          state_d = S_PFX0;
        end
      end

      S_PLC0: begin
        if (k_q == len_q) begin
          k_d     = '0;
          state_d = S_CPY0;
        end else begin
          state_d = S_PLC1;
        end
      end

      S_PLC1: begin
        key_d   = cur_key;
        sym_d   = tbuf_rd_q;
        state_d = S_PLC2;
      end

      S_PLC2: begin
        ordb_we = 1'b1;
        bkt_we  = 1'b1;
        k_d     = k_q + LW'(1);
        state_d = S_PLC0;
      end

      S_CPY0: begin
        if (k_q == len_q) begin
          if (lvl_q == DW'(bwt_pkg::LEVELS - 1)) begin
            built_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            lvl_d   = lvl_q + DW'(1);
            j_d     = '0;
            state_d = S_CLR;
          end
        end else begin
          state_d = S_CPY1;
        end
      end

      S_CPY1: begin
        tbuf_we = 1'b1;
        k_d     = k_q + LW'(1);
        state_d = S_CPY0;
      end

      // Query walk: three prefix-count reads per level on the shared port.
      S_Q0: begin
        state_d = S_Q1;
      end

      S_Q1: begin
        zp_d      = zpc_rd_q;
        bit_d     = q_bit;
        zpc_raddr = {lvl_q, pos_idx};
        state_d   = S_Q2;
      end

      S_Q2: begin
        dz_d      = zpc_rd_q - zp_q;
        zpc_raddr = {lvl_q, pos_len};
        state_d   = S_Q3;
      end

      S_Q3: begin
        pos_d   = step_pos;
        idx_d   = step_idx;
        wlen_d  = step_len;
        value_d = value_nx;
        if (lvl_q == DW'(bwt_pkg::LEVELS - 1)) begin
          valid_d  = 1'b1;
          error_d  = 1'b0;
          answer_d = acc_q ? bwt_pkg::ANS_W'(value_nx)
                           : idx_ext[bwt_pkg::ANS_W-1:0];
          state_d  = S_IDLE;
        end else begin
          lvl_d   = lvl_q + DW'(1);
          state_d = S_Q0;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      built_q <= 1'b0;
      k_q     <= '0;
      j_q     <= '0;
      lvl_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      built_q <= built_d;
      k_q     <= k_d;
      j_q     <= j_d;
      lvl_q   <= lvl_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zc_q     <= zc_d;
    sum_q    <= sum_d;
    key_q    <= key_d;
    sym_q    <= sym_d;
    acc_q    <= acc_d;
    qsym_q   <= qsym_d;
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    wlen_q   <= wlen_d;
    zp_q     <= zp_d;
    dz_q     <= dz_d;
    bit_q    <= bit_d;
    value_q  <= value_d;
    answer_q <= answer_d;
    error_q  <= error_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbuf_we) begin
      tbuf_mem[tbuf_waddr] <= tbuf_wdata;
    end
    tbuf_rd_q <= tbuf_mem[tbuf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ordb_we) begin
      ordb_mem[ordb_waddr] <= sym_q;
    end
    ordb_rd_q <= ordb_mem[k_q[KW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (lbit_we) begin
      lbit_mem[lbit_waddr] <= lbit_wdata;
    end
    lbit_rd_q <= lbit_mem[lbit_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (zpc_we) begin
      zpc_mem[zpc_waddr] <= zpc_wdata;
    end
    zpc_rd_q <= zpc_mem[zpc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rd_q <= bkt_mem[bkt_raddr];
  end

  assign busy     = (state_q != S_IDLE);
  assign valid_o  = valid_q;
  assign answer_o = answer_q;
  assign error_o  = error_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the byte wavelet tree block with load, access and rank commands.
`timescale 1ns / 1ps

// The testbench keeps its own copy of the loaded text and answers every query
// straight from that text. Access returns the stored byte. Rank counts the
// matching bytes below the position. A correct wavelet tree must give the
// same answers, so this checks the build and the tree walk end to end.
// Transactions are driven at the falling edge. Results are sampled at the
// rising edge and compared in order against a queue of predicted answers.
module tb_top;

  localparam int unsigned CAPACITY = bwt_pkg::MAX_LEN_DEF;

  typedef struct packed {
    logic [bwt_pkg::ANS_W-1:0] answer;
    logic                      error;
  } answer_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                cmd_i = bwt_pkg::CMD_NONE;
  logic [bwt_pkg::SYM_W-1:0] text_byte_i = '0;
  logic                      load_last_i = 1'b0;
  logic [bwt_pkg::POS_W-1:0] position_i = '0;
  logic [bwt_pkg::SYM_W-1:0] symbol_i = '0;
  logic                      valid_o;
  logic [bwt_pkg::ANS_W-1:0] answer_o;
  logic                      error_o;

  // Shadow of the block's text state.
  logic [bwt_pkg::SYM_W-1:0] shadow_text [CAPACITY];
  int unsigned               shadow_len = 0;
  bit                        shadow_built = 1'b0;

  answer_t     pending_answers[$];
  int unsigned mismatch_count = 0;

  byte_wavelet_tree_access_rank uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .text_byte_i (text_byte_i),
    .load_last_i (load_last_i),
    .position_i  (position_i),
    .symbol_i    (symbol_i),
    .valid_o     (valid_o),
    .answer_o    (answer_o),
    .error_o     (error_o)
  );

  always #4 clk_i = ~clk_i;

  // The run is cut off well beyond the slowest correct run, which is
  // dominated by the builds: one full-capacity build and the builds
  // of many short random texts.
  initial begin
    #(8 * 10_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Works out what one accepted transaction must return, and updates the
  // shadow text. Returns 1 when the transaction produces a result.
  function automatic bit predict_answer(input bwt_pkg::cmd_e cmd,
                                        input logic [bwt_pkg::SYM_W-1:0] byte_in,
                                        input logic last,
                                        input logic [bwt_pkg::POS_W-1:0] pos,
                                        input logic [bwt_pkg::SYM_W-1:0] sym,
                                        output answer_t res);
    int unsigned n;
    int unsigned p;
    int unsigned hits;
    bit produced;
    res = '0;
    produced = 1'b0;
    p = 32'(pos);
    case (cmd)
      bwt_pkg::CMD_LOAD: begin
        // A load after a finished build begins a new text.
        if (shadow_built) begin
          shadow_built = 1'b0;
          shadow_len = 0;
        end
        if (shadow_len < CAPACITY) begin
          shadow_text[shadow_len] = byte_in;
          shadow_len++;
        end else begin
          // Past capacity the byte is dropped and flagged.
          res.error = 1'b1;
          produced = 1'b1;
        end
        if (last) shadow_built = 1'b1;
      end
      bwt_pkg::CMD_ACCESS: begin
        n = shadow_built ? shadow_len : 32'd0;
        produced = 1'b1;
        if (p >= n) res.error = 1'b1;
        else res.answer = bwt_pkg::ANS_W'(shadow_text[p]);
      end
      bwt_pkg::CMD_RANK: begin
        n = shadow_built ? shadow_len : 32'd0;
        produced = 1'b1;
        if (p > n) begin
          res.error = 1'b1;
        end else begin
          hits = 0;
          for (int unsigned k = 0; k < p; k++) begin
            if (shadow_text[k] == sym) hits++;
          end
          res.answer = bwt_pkg::ANS_W'(hits);
        end
      end
      default: produced = 1'b0;
    endcase
    return produced;
  endfunction

  // Sends one transaction after an idle gap. The start line stays high when
  // there is no gap, so that back-to-back transactions never drop it.
  task automatic send_command(input bwt_pkg::cmd_e cmd,
                              input logic [bwt_pkg::SYM_W-1:0] byte_in,
                              input logic last,
                              input logic [bwt_pkg::POS_W-1:0] pos,
                              input logic [bwt_pkg::SYM_W-1:0] sym,
                              input int unsigned gap);
    answer_t res;
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start = 1'b1;
    cmd_i = cmd;
    text_byte_i = byte_in;
    load_last_i = last;
    position_i = pos;
    symbol_i = sym;
    // Busy only changes on the rising edge, so its value here holds at the next edge.
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    if (predict_answer(cmd, byte_in, last, pos, sym, res)) pending_answers.push_back(res);
  endtask

  function automatic int unsigned random_gap();
    // About a third of the transactions follow with no gap at all.
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  // Every result is compared with the oldest predicted answer.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && valid_o) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result answer=%0d error=%0b",
                                  answer_o, error_o));
      end else begin
        want = pending_answers.pop_front();
        if (answer_o !== want.answer) begin
          report_mismatch($sformatf("answer %0d, expected %0d", answer_o, want.answer));
        end
        if (error_o !== want.error) begin
          report_mismatch($sformatf("error %0b, expected %0b", error_o, want.error));
        end
      end
    end
  end

  // Queries against a text that was never built see an empty text.
  task automatic test_empty_text();
    send_command(bwt_pkg::CMD_ACCESS, 8'h00, 1'b0, 13'd0, 8'h00, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'd0, 8'h00, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'd1, 8'hFF, 1);
    send_command(bwt_pkg::CMD_ACCESS, 8'h00, 1'b0, 13'h1FFF, 8'h00, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'h1FFF, 8'hFF, 2);
    send_command(bwt_pkg::CMD_NONE, 8'hFF, 1'b1, 13'h1FFF, 8'hFF, 0);
  endtask

  // A short text with the extreme byte values and zero bytes.
  task automatic test_extreme_bytes();
    logic [bwt_pkg::SYM_W-1:0] bytes_in [5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00};
    for (int k = 0; k < 5; k++) begin
      send_command(bwt_pkg::CMD_LOAD, bytes_in[k], k == 4, 13'd0, 8'h00, 0);
    end
    for (int k = 0; k <= 5; k++) begin
      send_command(bwt_pkg::CMD_ACCESS, 8'h00, 1'b0, 13'(k), 8'h00, 0);
    end
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'd5, 8'h00, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'd5, 8'hFF, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'd3, 8'h80, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'd0, 8'h7F, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'd6, 8'h00, 0);
    send_command(bwt_pkg::CMD_ACCESS, 8'h00, 1'b0, 13'h1FFF, 8'h00, 0);
  endtask

  // Loads without a closing byte leave no built tree, so queries must fail.
  task automatic test_open_text();
    send_command(bwt_pkg::CMD_LOAD, 8'h55, 1'b0, 13'd0, 8'h00, 0);
    send_command(bwt_pkg::CMD_LOAD, 8'hAA, 1'b0, 13'd0, 8'h00, 3);
    send_command(bwt_pkg::CMD_ACCESS, 8'h00, 1'b0, 13'd0, 8'h00, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'd1, 8'h55, 0);
    send_command(bwt_pkg::CMD_LOAD, 8'h01, 1'b1, 13'd0, 8'h00, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'd3, 8'h55, 0);
  endtask

  // Fills the text to capacity with one symbol, then overflows it twice;
  // the second overflowing load also closes the text.
  task automatic test_capacity();
    for (int k = 0; k < CAPACITY; k++) begin
      send_command(bwt_pkg::CMD_LOAD, 8'h3C, 1'b0, 13'd0, 8'h00, 0);
    end
    send_command(bwt_pkg::CMD_LOAD, 8'hC3, 1'b0, 13'd0, 8'h00, 0);
    send_command(bwt_pkg::CMD_LOAD, 8'hC3, 1'b1, 13'd0, 8'h00, 4);
    send_command(bwt_pkg::CMD_ACCESS, 8'h00, 1'b0, 13'(CAPACITY - 1), 8'h00, 0);
    send_command(bwt_pkg::CMD_ACCESS, 8'h00, 1'b0, 13'(CAPACITY), 8'h00, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'(CAPACITY), 8'h3C, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'(CAPACITY + 1), 8'h3C, 0);
    send_command(bwt_pkg::CMD_RANK, 8'h00, 1'b0, 13'(CAPACITY), 8'hC3, 0);
  endtask

  // Random texts, mostly short, each followed by a burst of queries.
  // Symbols are often drawn from a small alphabet so that ranks get large.
  task automatic test_random_texts(input int unsigned budget);
    int unsigned sent;
    int unsigned text_size;
    int unsigned queries;
    int unsigned alphabet;
    logic [bwt_pkg::SYM_W-1:0] base_sym;
    logic [bwt_pkg::SYM_W-1:0] sym;
    logic [bwt_pkg::POS_W-1:0] pos;
    sent = 0;
    while (sent < budget) begin
      text_size = ($urandom_range(0, 15) == 0) ? $urandom_range(33, 300)
                                                : $urandom_range(1, 32);
      alphabet = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(0, 3);
      base_sym = bwt_pkg::SYM_W'($urandom);
      for (int unsigned k = 0; k < text_size; k++) begin
        sym = (alphabet == 255) ? bwt_pkg::SYM_W'($urandom)
                                : base_sym + bwt_pkg::SYM_W'($urandom_range(0, alphabet));
        send_command(bwt_pkg::CMD_LOAD, sym, k == text_size - 1,
                     bwt_pkg::POS_W'($urandom), bwt_pkg::SYM_W'($urandom), random_gap());
        sent++;
      end
      queries = $urandom_range(5, 30);
      for (int unsigned q = 0; q < queries; q++) begin
        case ($urandom_range(0, 9))
          0: pos = bwt_pkg::POS_W'($urandom);
          1: pos = bwt_pkg::POS_W'(text_size + $urandom_range(0, 1));
          default: pos = bwt_pkg::POS_W'($urandom_range(0, text_size));
        endcase
        sym = ($urandom_range(0, 2) == 0) ? bwt_pkg::SYM_W'($urandom)
                                          : shadow_text[$urandom_range(0, text_size - 1)];
        case ($urandom_range(0, 19))
          0: send_command(bwt_pkg::CMD_NONE, bwt_pkg::SYM_W'($urandom), 1'($urandom),
                          pos, sym, random_gap());
          1: begin
            // An occasional stray load reopens the text; later queries then see an empty text.
            send_command(bwt_pkg::CMD_LOAD, bwt_pkg::SYM_W'($urandom), 1'b0, pos, sym,
                         random_gap());
            sent++;
          end
          2, 3, 4, 5, 6, 7, 8, 9:
            send_command(bwt_pkg::CMD_ACCESS, bwt_pkg::SYM_W'($urandom), 1'($urandom),
                         pos, sym, random_gap());
          default: send_command(bwt_pkg::CMD_RANK, bwt_pkg::SYM_W'($urandom), 1'($urandom),
                                pos, sym, random_gap());
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned drain_cycles;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_text();
    test_extreme_bytes();
    test_open_text();
    test_random_texts(1000);
    test_capacity();

    @(negedge clk_i);
    start = 1'b0;
    // Wait for the last answers; the loop below gives up if they never arrive.
    drain_cycles = 0;
    while (pending_answers.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (50) @(posedge clk_i);

    if (pending_answers.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
